/* hdl/mie_pkg.sv */
// Shared types and constants for the modular inverse block.
// Used by mie_ctrl, mie_dpath and modular_inverse_ext_euclid; no dependencies.

package mie_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DATA_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_FINAL
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // capture operands, set up Euclid state
        logic div_init;  // clear divider for a new quotient
        logic div_step;  // one restoring-division bit
        logic update;    // shift the remainder and coefficient sequences
        logic finish;    // normalize and present the result word
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic rcur_zero; // current remainder is zero: Euclid loop done
        logic div_last;  // this division bit is the last one
    } t_dp_stat;

endpackage

/* hdl/modular_inverse_ext_euclid.sv */
// Top level of the modular inverse block (extended Euclidean algorithm).
// Instantiates mie_ctrl and mie_dpath; depends on mie_pkg.
// Usage:
//   Drive i_value and i_modulus and raise start. The word is taken at the
//   rising edge where start is high and busy is low; busy then stays high
//   until the result has been produced.
//   The result word (o_inverse, o_exists, o_divisor) appears for exactly one
//   cycle, marked by o_done. The receiver cannot stall: capture it then.
//   o_divisor is gcd(value, modulus). o_exists is 1 when the gcd is 1 and the
//   modulus is nonzero; o_inverse is then the inverse in 0..modulus-1, else 0.
// Sequence:
//   Each Euclid step is a check state, then DATA_W steps of the bit-serial
//   restoring divider (which also accumulates quotient times coefficient),
//   then one update state. The next word can be accepted in the cycle
//   o_done is high.
// Reset:
//   i_rst_n is synchronous, active low; it returns the sequencer to idle and
//   drops o_done. Any word in flight is lost.

module modular_inverse_ext_euclid
    import mie_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_modulus,
    output logic              o_done,
    output logic [DATA_W-1:0] o_inverse,
    output logic              o_exists,
    output logic [DATA_W-1:0] o_divisor
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer: check, divide bit by bit, update, repeat until remainder zero
    mie_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (dp_stat),
        .busy    (busy),
        .o_cmd   (dp_cmd)
    );

    // Remainder and coefficient sequences, divider and result registers
    mie_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (dp_cmd),
        .i_value   (i_value),
        .i_modulus (i_modulus),
        .o_stat    (dp_stat),
        .o_done    (o_done),
        .o_inverse (o_inverse),
        .o_exists  (o_exists),
        .o_divisor (o_divisor)
    );

endmodule

/* hdl/mie_ctrl.sv */
// Sequencer for the extended Euclid loop.
// Depends on mie_pkg; drives the command struct of mie_dpath.

module mie_ctrl
    import mie_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_dp_stat i_stat,
    output logic     busy,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_stat.rcur_zero) n_state = ST_FINAL;
                else                  n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_stat.div_last) n_state = ST_UPDATE;
            end
            ST_UPDATE: n_state = ST_CHECK;
            ST_FINAL:  n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            ST_CHECK:  o_cmd.div_init = ~i_stat.rcur_zero;
            ST_DIV:    o_cmd.div_step = 1'b1;
            ST_UPDATE: o_cmd.update   = 1'b1;
            ST_FINAL:  o_cmd.finish   = 1'b1;
            default:   busy           = 1'b1;
        endcase
    end

endmodule

/* hdl/mie_dpath.sv */
// Datapath for the extended Euclid loop: remainder and coefficient registers,
// a bit-serial restoring divider with quotient-times-coefficient accumulate,
// and final normalization. Depends on mie_pkg.

module mie_dpath
    import mie_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_modulus,
    output t_dp_stat          o_stat,
    output logic              o_done,
    output logic [DATA_W-1:0] o_inverse,
    output logic              o_exists,
    output logic [DATA_W-1:0] o_divisor
);

    logic [DATA_W-1:0] r_mod;
    logic [DATA_W-1:0] r_rprev, r_rcur;
    logic [DATA_W-1:0] r_uprev, r_ucur;
    logic              r_odd;
    logic [DATA_W-1:0] r_quo, r_rem, r_acc;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [DATA_W-1:0] r_inverse, r_divisor;
    logic              r_exists;

    logic [DATA_W:0]   shifted;
    logic              ge;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] n_rem, n_acc;
    logic [DATA_W-1:0] mag;
    logic              ex;
    logic [DATA_W-1:0] inv;

    // One restoring-division bit; accumulate q * u_cur MSB first
    always_comb begin
        shifted = {r_rem, r_quo[DATA_W-1]};
        ge      = shifted >= {1'b0, r_rcur};
        diff    = shifted - {1'b0, r_rcur};
        n_rem   = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
        n_acc   = {r_acc[DATA_W-2:0], 1'b0} + (ge ? r_ucur : '0);
    end

    // u_prev never exceeds the modulus, so one compare-subtract reduces it
    always_comb begin
        mag = (r_uprev >= r_mod) ? (r_uprev - r_mod) : r_uprev;
        ex  = (r_mod != '0) && (r_rprev == DATA_W'(1));
        inv = '0;
        if (ex) begin
            if (r_odd && mag != '0) inv = r_mod - mag;
            else                    inv = mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mod   <= i_modulus;
            r_rprev <= i_value;
            r_rcur  <= i_modulus;
            r_uprev <= DATA_W'(1);
            r_ucur  <= '0;
            r_odd   <= 1'b0;
        end
        if (i_cmd.div_init) begin
            r_quo <= r_rprev;
            r_rem <= '0;
            r_acc <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[DATA_W-2:0], ge};
            r_rem <= n_rem;
            r_acc <= n_acc;
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.update) begin
            r_rprev <= r_rcur;
            r_rcur  <= r_rem;
            r_uprev <= r_ucur;
            r_ucur  <= r_uprev + r_acc;
            r_odd   <= ~r_odd;
        end
        if (i_cmd.finish) begin
            r_inverse <= inv;
            r_exists  <= ex;
            r_divisor <= r_rprev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    assign o_stat.rcur_zero = (r_rcur == '0);
    assign o_stat.div_last  = (r_cnt == CNT_W'(DATA_W - 1));
    assign o_done    = r_done;
    assign o_inverse = r_inverse;
    assign o_exists  = r_exists;
    assign o_divisor = r_divisor;

endmodule
